// File: hw/rtl/gcr_pkg.sv
// Shared types, constants and elaboration-time tables for the gamma/contrast ramp block.
package gcr_pkg;

    localparam int LOG_FRAC = 16;
    localparam int D_W      = 19;
    localparam int P_W      = 31;
    localparam int S_W      = 30;
    localparam logic [P_W-1:0] Q30_ONE = 31'h4000_0000;

    localparam logic [15:0] CFG_RESET = 16'd4096;

    localparam logic [3:0] REG_GAMMA_ALL      = 4'd0;
    localparam logic [3:0] REG_GAMMA_RED      = 4'd1;
    localparam logic [3:0] REG_GAMMA_GREEN    = 4'd2;
    localparam logic [3:0] REG_GAMMA_BLUE     = 4'd3;
    localparam logic [3:0] REG_CONTRAST_ALL   = 4'd4;
    localparam logic [3:0] REG_CONTRAST_RED   = 4'd5;
    localparam logic [3:0] REG_CONTRAST_GREEN = 4'd6;
    localparam logic [3:0] REG_CONTRAST_BLUE  = 4'd7;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic       vld;
        logic [1:0] ch;
    } tag_t;

    typedef logic [D_W-1:0] dtab_t [256];
    typedef logic [S_W-1:0] stab_t [LOG_FRAC];

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bt;
        x   = x_in;
        res = 64'd0;
        bt  = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [D_W-1:0] log2_q16(input logic [7:0] x);
        logic [63:0]         m;
        logic [LOG_FRAC-1:0] fr;
        int                  ip;
        ip = 0;
        fr = '0;
        for (int j = 0; j < 7; j++) begin
            if ((x >> (j + 1)) != 8'd0) ip = j + 1;
        end
        m = ({56'd0, x} << 30) >> ip;
        for (int i = 0; i < LOG_FRAC; i++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd2 << 30)) begin
                fr[0] = 1'b1;
                m     = m >> 1;
            end
        end
        return {ip[2:0], fr};
    endfunction

    // log2(255) - log2(b), floored at zero
    function automatic dtab_t build_dtab();
        dtab_t          t;
        logic [D_W-1:0] l255;
        logic [D_W-1:0] lb;
        l255 = log2_q16(8'd255);
        t[0] = '0;
        for (int b = 1; b < 256; b++) begin
            lb   = log2_q16(b[7:0]);
            t[b] = (l255 > lb) ? (l255 - lb) : '0;
        end
        return t;
    endfunction

    // factors 2^(-2^-i), i = 1..16, in Q30
    function automatic stab_t build_stab();
        stab_t       t;
        logic [63:0] s;
        s = 64'd1 << 29;
        for (int i = 0; i < LOG_FRAC; i++) begin
            s    = isqrt64(s << 30);
            t[i] = s[S_W-1:0];
        end
        return t;
    endfunction

    localparam dtab_t DTAB = build_dtab();
    localparam stab_t STAB = build_stab();

endpackage

// File: hw/rtl/gamma_contrast_ramp_entry.sv
// Top level: gamma and contrast correction of one ramp entry per transfer.
//
// Input channel s_*: one ramp entry (s_base_level) and its color channel
// (s_channel: red, green, blue; code three uses blue). Result channel m_*:
// the corrected entry m_adjusted_level, one result per input transfer, in order.
// Config channel cfg_*: register index and 16-bit data, always ready; indexes
// beyond the eight registers are dropped. Write config only while idle.
// The datapath is two gamma stages (19 register stages each: table lookup,
// exponent multiply, sixteen exp2 multiply steps, round) and two contrast
// stages (2 each). Throughput is one entry per cycle unless an output stall
// holds the pipeline; every stage advances together.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads every gain register with 1.0 (4096).
module gamma_contrast_ramp_entry #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_channel,
    input  logic [15:0] s_base_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_adjusted_level,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] gamma_all_reg, gamma_red_reg, gamma_green_reg, gamma_blue_reg;
    logic [15:0] con_all_reg, con_red_reg, con_green_reg, con_blue_reg;

    logic          adv;
    gcr_pkg::tag_t tag_s, tag_g1, tag_g2, tag_c1, tag_c2;
    logic [7:0]    byte_g1, byte_g2;
    logic [15:0]   lvl_c1, lvl_c2;
    logic [15:0]   gamma_ch;
    logic [15:0]   con_ch;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_all_reg   <= gcr_pkg::CFG_RESET;
            gamma_red_reg   <= gcr_pkg::CFG_RESET;
            gamma_green_reg <= gcr_pkg::CFG_RESET;
            gamma_blue_reg  <= gcr_pkg::CFG_RESET;
            con_all_reg     <= gcr_pkg::CFG_RESET;
            con_red_reg     <= gcr_pkg::CFG_RESET;
            con_green_reg   <= gcr_pkg::CFG_RESET;
            con_blue_reg    <= gcr_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                gcr_pkg::REG_GAMMA_ALL:      gamma_all_reg   <= cfg_data;
                gcr_pkg::REG_GAMMA_RED:      gamma_red_reg   <= cfg_data;
                gcr_pkg::REG_GAMMA_GREEN:    gamma_green_reg <= cfg_data;
                gcr_pkg::REG_GAMMA_BLUE:     gamma_blue_reg  <= cfg_data;
                gcr_pkg::REG_CONTRAST_ALL:   con_all_reg     <= cfg_data;
                gcr_pkg::REG_CONTRAST_RED:   con_red_reg     <= cfg_data;
                gcr_pkg::REG_CONTRAST_GREEN: con_green_reg   <= cfg_data;
                gcr_pkg::REG_CONTRAST_BLUE:  con_blue_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // the last contrast register doubles as the output register
    assign adv     = !tag_c2.vld || m_ready;
    assign s_ready = adv;

    assign tag_s.vld = s_valid;
    assign tag_s.ch  = s_channel;

    always_comb begin
        case (tag_g1.ch)
            gcr_pkg::CH_RED:   gamma_ch = gamma_red_reg;
            gcr_pkg::CH_GREEN: gamma_ch = gamma_green_reg;
            default:           gamma_ch = gamma_blue_reg;
        endcase
        case (tag_c1.ch)
            gcr_pkg::CH_RED:   con_ch = con_red_reg;
            gcr_pkg::CH_GREEN: con_ch = con_green_reg;
            default:           con_ch = con_blue_reg;
        endcase
    end

    gcr_gamma #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gamma_all (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .tag_in(tag_s), .byte_in(s_base_level[15:8]), .gamma_in(gamma_all_reg),
        .tag_out(tag_g1), .byte_out(byte_g1)
    );

    gcr_gamma #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_gamma_ch (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .tag_in(tag_g1), .byte_in(byte_g1), .gamma_in(gamma_ch),
        .tag_out(tag_g2), .byte_out(byte_g2)
    );

    gcr_contrast #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_con_all (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .tag_in(tag_g2), .level_in({byte_g2, 8'd0}), .gain_in($signed(con_all_reg)),
        .tag_out(tag_c1), .level_out(lvl_c1)
    );

    gcr_contrast #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_con_ch (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .tag_in(tag_c1), .level_in(lvl_c1), .gain_in($signed(con_ch)),
        .tag_out(tag_c2), .level_out(lvl_c2)
    );

    assign m_valid          = tag_c2.vld;
    assign m_adjusted_level = lvl_c2;

endmodule

// File: hw/rtl/gcr_gamma.sv
// One gamma stage: log-difference lookup, exponent multiply, 16-step exp2 chain, rounding.
module gcr_gamma #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  gcr_pkg::tag_t tag_in,
    input  logic [7:0]    byte_in,
    input  logic [15:0]   gamma_in,
    output gcr_pkg::tag_t tag_out,
    output logic [7:0]    byte_out
);

    localparam int NF = gcr_pkg::LOG_FRAC;
    localparam int PW = gcr_pkg::D_W + 16;
    localparam int MW = gcr_pkg::P_W + gcr_pkg::S_W;
    localparam int VW = gcr_pkg::P_W + 9;

    gcr_pkg::tag_t              t0_reg;
    logic [gcr_pkg::D_W-1:0]    d0_reg;
    logic [15:0]                g0_reg;
    logic                       z0_reg;

    gcr_pkg::tag_t              t_reg [NF+1];
    logic [gcr_pkg::P_W-1:0]    p_reg [NF+1];
    logic [NF-1:0]              f_reg [NF+1];
    logic [4:0]                 n_reg [NF+1];
    logic                       z_reg [NF+1];

    gcr_pkg::tag_t              to_reg;
    logic [7:0]                 bo_reg;

    logic [PW-1:0]              prod;
    logic [PW-1:0]              e_next;
    logic                       huge;
    logic [gcr_pkg::P_W-1:0]    shifted;
    logic [VW-1:0]              v_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t0_reg.vld <= 1'b0;
        end else if (en) begin
            t0_reg <= tag_in;
            d0_reg <= gcr_pkg::DTAB[byte_in];
            g0_reg <= gamma_in;
            // zero top byte with nonzero gamma gives zero
            z0_reg <= (byte_in == 8'd0) && (gamma_in != 16'd0);
        end
    end

    assign prod   = PW'(d0_reg) * PW'(g0_reg);
    assign e_next = prod >> GAIN_FRAC_BITS;
    assign huge   = (e_next[PW-1:NF] >= (PW-NF)'(31));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_reg[0].vld <= 1'b0;
        end else if (en) begin
            t_reg[0] <= t0_reg;
            p_reg[0] <= gcr_pkg::Q30_ONE;
            f_reg[0] <= e_next[NF-1:0];
            n_reg[0] <= e_next[NF+4:NF];
            z_reg[0] <= z0_reg || huge;
        end
    end

    for (genvar k = 1; k <= NF; k++) begin : g_mul
        logic [MW-1:0] mul;
        assign mul = MW'(p_reg[k-1]) * MW'(gcr_pkg::STAB[k-1]);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                t_reg[k].vld <= 1'b0;
            end else if (en) begin
                t_reg[k] <= t_reg[k-1];
                p_reg[k] <= f_reg[k-1][NF-k] ? mul[30 +: gcr_pkg::P_W] : p_reg[k-1];
                f_reg[k] <= f_reg[k-1];
                n_reg[k] <= n_reg[k-1];
                z_reg[k] <= z_reg[k-1];
            end
        end
    end

    assign shifted = p_reg[NF] >> n_reg[NF];
    assign v_next  = ((VW'(shifted) << 8) - VW'(shifted) + (VW'(1) << 29)) >> 30;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            to_reg.vld <= 1'b0;
        end else if (en) begin
            to_reg <= t_reg[NF];
            if (z_reg[NF]) begin
                bo_reg <= 8'd0;
            end else if (v_next > VW'(255)) begin
                bo_reg <= 8'd255;
            end else begin
                bo_reg <= v_next[7:0];
            end
        end
    end

    assign tag_out  = to_reg;
    assign byte_out = bo_reg;

endmodule

// File: hw/rtl/gcr_contrast.sv
// One contrast stage: signed gain about the midpoint, floor shift and clamp.
module gcr_contrast #(
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  gcr_pkg::tag_t      tag_in,
    input  logic [15:0]        level_in,
    input  logic signed [15:0] gain_in,
    output gcr_pkg::tag_t      tag_out,
    output logic [15:0]        level_out
);

    gcr_pkg::tag_t       ta_reg;
    logic signed [32:0]  prod_reg;
    gcr_pkg::tag_t       tb_reg;
    logic [15:0]         lvl_reg;

    logic signed [16:0]  diff;
    logic signed [32:0]  q;
    logic signed [33:0]  r;

    assign diff = $signed({1'b0, level_in}) - 17'sd32767;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ta_reg.vld <= 1'b0;
        end else if (en) begin
            ta_reg   <= tag_in;
            prod_reg <= 33'(diff) * 33'(gain_in);
        end
    end

    // arithmetic shift floors toward minus infinity
    assign q = prod_reg >>> GAIN_FRAC_BITS;
    assign r = 34'(q) + 34'sd32767;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg.vld <= 1'b0;
        end else if (en) begin
            tb_reg <= ta_reg;
            if (r < 34'sd0) begin
                lvl_reg <= 16'd0;
            end else if (r > 34'sd65535) begin
                lvl_reg <= 16'hFFFF;
            end else begin
                lvl_reg <= r[15:0];
            end
        end
    end

    assign tag_out   = tb_reg;
    assign level_out = lvl_reg;

endmodule

// File: hw/rtl/gcr_checker.sv
// Port-level checks for the ramp entry block, bound to the top level.
module gcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_adjusted_level,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_adjusted_level))
        else $error("result changed while stalled");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind gamma_contrast_ramp_entry gcr_checker u_gcr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_adjusted_level(m_adjusted_level),
    .cfg_ready(cfg_ready)
);
